// ----- design/ffra_pkg.sv -----
`default_nettype none
package ffra_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int FIELD_W   = 11;
	localparam int WORD_BITS = 8;
	localparam int WB_LOG    = 3;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef struct packed {
		logic load_cfg;
		logic load_req;
		logic clr_step;
		logic scan_init;
		logic scan_step;
		logic mark_init;
		logic mark_rd;
		logic mark_wr;
		logic out_load;
	} ffra_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic req_skip;
		logic clr_last;
		logic scan_found;
		logic scan_miss;
		logic mark_last;
		logic out_free;
	} ffra_sts_t;

endpackage
`default_nettype wire

// ----- design/ffra_ram.sv -----
`default_nettype none
module ffra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- design/ffra_ctrl.sv -----
`default_nettype none
module ffra_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              in_valid,
	input  wire ffra_pkg::ffra_sts_t sts,
	output ffra_pkg::ffra_cmd_t    cmd,
	output logic                   in_stall,
	output logic                   cfg_ready
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_MRD,
		ST_MWR,
		ST_OUT
	} state_t;

	state_t state_q;

	assign cfg_ready = (state_q == ST_IDLE);
	// config has priority, so never take a request in the same cycle
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				cmd.load_cfg = cfg_valid;
				cmd.load_req = in_valid && !cfg_valid;
			end
			ST_DECIDE: begin
				cmd.scan_init = sts.is_alloc && !sts.req_skip;
				cmd.mark_init = !sts.is_alloc && !sts.req_skip;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.mark_init = sts.scan_found;
			end
			ST_MRD: cmd.mark_rd = 1'b1;
			ST_MWR: cmd.mark_wr = 1'b1;
			ST_OUT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cfg_valid) state_q <= ST_CLEAR;
					else if (in_valid) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (sts.is_alloc) state_q <= sts.req_skip ? ST_OUT : ST_SCAN;
					else state_q <= sts.req_skip ? ST_IDLE : ST_MRD;
				end
				ST_SCAN: begin
					if (sts.scan_found) state_q <= ST_MRD;
					else if (sts.scan_miss) state_q <= ST_OUT;
				end
				ST_MRD: state_q <= ST_MWR;
				ST_MWR: begin
					if (sts.mark_last) state_q <= sts.is_alloc ? ST_OUT : ST_IDLE;
					else state_q <= ST_MRD;
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/ffra_dp.sv -----
`default_nettype none
module ffra_dp #(
	parameter int SLOTS = ffra_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ffra_pkg::ffra_cmd_t           cmd,
	output ffra_pkg::ffra_sts_t                sts,
	input  wire logic [ffra_pkg::FIELD_W-1:0]  slot_count,
	input  wire logic                          req_type,
	input  wire logic [ffra_pkg::FIELD_W-1:0]  start_slot,
	input  wire logic [ffra_pkg::FIELD_W-1:0]  run_length,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               found,
	output logic [ffra_pkg::FIELD_W-1:0]       alloc_start
);

	localparam int WB  = ffra_pkg::WORD_BITS;
	localparam int WL  = ffra_pkg::WB_LOG;
	localparam int FW  = ffra_pkg::FIELD_W;
	localparam int NW  = (SLOTS + WB - 1) / WB;
	localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int PW0 = $clog2(SLOTS + 1) + 1;
	localparam int PW  = (PW0 > FW + 1) ? PW0 : FW + 1;

	// slot row as a bitmap, one bit per slot, set means used
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [WB-1:0] wdata, rdata;

	ffra_ram #(.WIDTH(WB), .DEPTH(NW), .AW(AW)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	logic [PW-1:0] count_q;
	logic [AW-1:0] clr_q;
	logic          type_q;
	logic [PW-1:0] start_q, len_q;
	logic [AW:0]   rd_q;
	logic          pv_s1;
	logic [AW-1:0] addr_s1;
	logic [PW-1:0] run_q, rs_q, fstart_q;
	logic          found_q;
	logic [PW-1:0] ma_q, mb_q;
	logic          mset_q;
	logic [AW-1:0] wp_q, wl_q;
	logic          ov_q, ofound_q;
	logic [FW-1:0] ostart_q;

	logic [PW-1:0] cfg_v, rel_a, rel_b, rel_end;
	logic          rel_skip;
	logic [PW-1:0] ma_n, mb_n, ma_m1, mb_m1;
	logic [PW-1:0] run_n, rs_n, fs_n, scan_base, slot_v;
	logic          fnd_n;
	logic [PW-1:0] clr_base, mark_base, cslot, mslot;
	logic [WB-1:0] clr_word, mark_word;

	always_comb begin
		cfg_v = PW'(slot_count);
		if (cfg_v == '0) cfg_v = PW'(1);
		if (cfg_v > PW'(SLOTS)) cfg_v = PW'(SLOTS);
	end

	// release range clipped to slots 1..count
	assign rel_end  = start_q + len_q - PW'(1);
	assign rel_a    = (start_q == '0) ? PW'(1) : start_q;
	assign rel_b    = (rel_end > count_q) ? count_q : rel_end;
	assign rel_skip = (len_q == '0) || (rel_a > rel_b);

	assign ma_n  = (type_q == ffra_pkg::REQ_ALLOC) ? fstart_q : rel_a;
	assign mb_n  = (type_q == ffra_pkg::REQ_ALLOC) ? fstart_q + len_q - PW'(1) : rel_b;
	assign ma_m1 = ma_n - PW'(1);
	assign mb_m1 = mb_n - PW'(1);

	// first-fit run tracking over one bitmap word
	assign scan_base = PW'({addr_s1, WL'(0)}) + PW'(1);
	always_comb begin
		run_n  = run_q;
		rs_n   = rs_q;
		fnd_n  = found_q;
		fs_n   = fstart_q;
		slot_v = '0;
		for (int i = 0; i < WB; i++) begin
			slot_v = scan_base + PW'(i);
			if (rdata[i]) begin
				run_n = '0;
			end else begin
				if (run_n == '0) rs_n = slot_v;
				run_n = run_n + PW'(1);
				if (!fnd_n && run_n == len_q) begin
					fnd_n = 1'b1;
					fs_n  = rs_n;
				end
			end
		end
	end

	assign clr_base  = PW'({clr_q, WL'(0)}) + PW'(1);
	assign mark_base = PW'({wp_q, WL'(0)}) + PW'(1);
	always_comb begin
		cslot = '0;
		mslot = '0;
		for (int i = 0; i < WB; i++) begin
			cslot        = clr_base + PW'(i);
			mslot        = mark_base + PW'(i);
			clr_word[i]  = cslot > count_q;
			mark_word[i] = (mslot >= ma_q && mslot <= mb_q) ? mset_q : rdata[i];
		end
	end

	assign we    = cmd.clr_step || cmd.mark_wr;
	assign waddr = cmd.clr_step ? clr_q : wp_q;
	assign wdata = cmd.clr_step ? clr_word : mark_word;
	assign raddr = cmd.mark_rd ? wp_q : rd_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= PW'(SLOTS);
			clr_q   <= '0;
			rd_q    <= '0;
			pv_s1   <= 1'b0;
			found_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.load_cfg) begin
				count_q <= cfg_v;
				clr_q   <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.load_req || cmd.scan_init) begin
				rd_q    <= '0;
				pv_s1   <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				pv_s1 <= (rd_q != (AW+1)'(NW));
				if (rd_q != (AW+1)'(NW)) rd_q <= rd_q + (AW+1)'(1);
				if (pv_s1 && !found_q) found_q <= fnd_n;
			end
			if (cmd.out_load) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q  <= req_type;
			start_q <= PW'(start_slot);
			len_q   <= PW'(run_length);
		end
		if (cmd.scan_init) begin
			run_q <= '0;
			rs_q  <= '0;
		end else if (cmd.scan_step) begin
			addr_s1 <= rd_q[AW-1:0];
			if (pv_s1 && !found_q) begin
				run_q    <= run_n;
				rs_q     <= rs_n;
				fstart_q <= fs_n;
			end
		end
		if (cmd.mark_init) begin
			ma_q   <= ma_n;
			mb_q   <= mb_n;
			mset_q <= (type_q == ffra_pkg::REQ_ALLOC);
			wp_q   <= ma_m1[AW+WL-1:WL];
			wl_q   <= mb_m1[AW+WL-1:WL];
		end else if (cmd.mark_wr) begin
			wp_q <= wp_q + AW'(1);
		end
		if (cmd.out_load) begin
			ofound_q <= found_q;
			ostart_q <= found_q ? fstart_q[FW-1:0] : '0;
		end
	end

	assign sts.is_alloc   = (type_q == ffra_pkg::REQ_ALLOC);
	assign sts.req_skip   = (type_q == ffra_pkg::REQ_ALLOC) ? (len_q == '0) : rel_skip;
	assign sts.clr_last   = (clr_q == AW'(NW - 1));
	assign sts.scan_found = found_q;
	assign sts.scan_miss  = !found_q && !pv_s1 && (rd_q == (AW+1)'(NW));
	assign sts.mark_last  = (wp_q == wl_q);
	assign sts.out_free   = !ov_q || !out_stall;

	assign out_valid   = ov_q;
	assign found       = ofound_q;
	assign alloc_start = ostart_q;

endmodule
`default_nettype wire

// ----- design/first_fit_run_allocator.sv -----
// allocate: the request is loaded and decided, then a first-fit scan takes one
// 8-slot bitmap word per cycle, then each bitmap word marked used is read and
// written back, and the result register is loaded once the output is free
// release: loaded and decided, then each bitmap word touched is read and written
// back; one request at a time; an empty request skips the scan and the marking
// the bitmap memory has one read and one write port; marking is read-modify-write
// after reset and each slot_count write the bitmap is rebuilt; no request is taken meanwhile
`default_nettype none
module first_fit_run_allocator #(
	parameter int SLOTS = ffra_pkg::SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [ffra_pkg::FIELD_W-1:0] slot_count,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         req_type,
	input  wire logic [ffra_pkg::FIELD_W-1:0] start_slot,
	input  wire logic [ffra_pkg::FIELD_W-1:0] run_length,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              found,
	output logic [ffra_pkg::FIELD_W-1:0]      alloc_start
);

	ffra_pkg::ffra_cmd_t cmd;
	ffra_pkg::ffra_sts_t sts;

	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.in_valid  (in_valid),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready)
	);

	ffra_dp #(.SLOTS(SLOTS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.slot_count  (slot_count),
		.req_type    (req_type),
		.start_slot  (start_slot),
		.run_length  (run_length),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.alloc_start (alloc_start)
	);

	a_no_dual_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall && cfg_valid && cfg_ready))
		else $error("request and config taken together");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (alloc_start == '0))
		else $error("nonzero start on a miss");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (alloc_start != '0))
		else $error("zero start on a hit");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;

	localparam int SLOTS     = ffra_pkg::SLOTS_DEF;
	localparam int SETTLE    = 400;
	localparam int IDLE_LIMIT = 20000;
	localparam int RAND_ITEMS = 500;

	typedef struct {
		logic                          kind;
		logic [ffra_pkg::FIELD_W-1:0]  first;
		logic [ffra_pkg::FIELD_W-1:0]  len;
		bit                            typed;
		logic                          t_found;
		logic [ffra_pkg::FIELD_W-1:0]  t_start;
	} row_t;

	typedef struct {
		logic                         found;
		logic [ffra_pkg::FIELD_W-1:0] start;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ffra_pkg::FIELD_W-1:0] slot_count = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = ffra_pkg::REQ_ALLOC;
	logic [ffra_pkg::FIELD_W-1:0] start_slot = '0;
	logic [ffra_pkg::FIELD_W-1:0] run_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic [ffra_pkg::FIELD_W-1:0] alloc_start;

	// typed expectation travels with the request
	bit row_typed = 1'b0;
	logic row_found = 1'b0;
	logic [ffra_pkg::FIELD_W-1:0] row_start = '0;

	bit used_map [1:SLOTS];
	int live_slots;
	grant_t grant_q[$];
	int errors = 0;
	int idle_cycles = 0;

	first_fit_run_allocator #(.SLOTS(SLOTS)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slot_count(slot_count),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.start_slot(start_slot), .run_length(run_length),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .alloc_start(alloc_start)
	);

	always #4 clk = ~clk;

	function automatic void rebuild_map(int cnt);
		for (int i = 1; i <= SLOTS; i++)
			used_map[i] = (i > cnt);
		live_slots = cnt;
	endfunction

	// lowest start of a free run of len slots
	function automatic grant_t first_fit(int len);
		grant_t g;
		int run;
		g.found = 1'b0;
		g.start = '0;
		run = 0;
		if (len == 0)
			return g;
		for (int i = 1; i <= SLOTS; i++) begin
			run = used_map[i] ? 0 : run + 1;
			if (run == len) begin
				for (int j = i - len + 1; j <= i; j++)
					used_map[j] = 1'b1;
				g.found = 1'b1;
				g.start = ffra_pkg::FIELD_W'(i - len + 1);
				return g;
			end
		end
		return g;
	endfunction

	function automatic void free_run(int first, int len);
		int lo, hi;
		if (len == 0)
			return;
		lo = (first < 1) ? 1 : first;
		hi = first + len - 1;
		if (hi > live_slots)
			hi = live_slots;
		for (int i = lo; i <= hi; i++)
			used_map[i] = 1'b0;
	endfunction

	always @(posedge clk) begin
		grant_t g;
		if (in_valid && !in_stall) begin
			if (req_type == ffra_pkg::REQ_ALLOC) begin
				g = first_fit(run_length);
				if (row_typed) begin
					g.found = row_found;
					g.start = row_start;
				end
				grant_q.push_back(g);
			end else begin
				free_run(start_slot, run_length);
			end
		end
		if (out_valid && !out_stall) begin
			if (grant_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected grant found=%0d start=%0d", found, alloc_start);
			end else begin
				g = grant_q.pop_front();
				if (found !== g.found || alloc_start !== g.start) begin
					errors++;
					if (errors <= 10)
						$display("grant mismatch: exp found=%0d start=%0d got found=%0d start=%0d",
							g.found, g.start, found, alloc_start);
				end
			end
		end
	end

	// receiver stall pattern: quiet stretches and busy stretches
	always @(posedge clk) begin
		int mode_left;
		bit busy_mode;
		if (mode_left <= 0) begin
			mode_left = $urandom_range(200, 20);
			busy_mode = 1'($urandom_range(1, 0));
		end
		mode_left--;
		out_stall <= busy_mode ? ($urandom_range(2, 0) == 0) : 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_count(logic [ffra_pkg::FIELD_W-1:0] v);
		int cnt;
		@(posedge clk);
		cfg_valid <= 1'b1;
		slot_count <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cnt = (v < 1) ? 1 : (v > SLOTS) ? SLOTS : v;
		rebuild_map(cnt);
	endtask

	int burst_left = 0;

	task automatic send(row_t r);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(12, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= r.kind;
		start_slot <= r.first;
		run_length <= r.len;
		row_typed <= r.typed;
		row_found <= r.t_found;
		row_start <= r.t_start;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (grant_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic row_t pick(int cnt);
		row_t r;
		r.typed = 1'b0;
		r.t_found = 1'b0;
		r.t_start = '0;
		r.kind = ($urandom_range(9, 0) < 6) ? ffra_pkg::REQ_ALLOC : ffra_pkg::REQ_RELEASE;
		if ($urandom_range(19, 0) == 0) begin
			r.first = ffra_pkg::FIELD_W'($urandom);
			r.len = ffra_pkg::FIELD_W'($urandom);
		end else begin
			r.first = ffra_pkg::FIELD_W'($urandom_range(cnt + 2, 0));
			r.len = ($urandom_range(3, 0) == 0)
				? ffra_pkg::FIELD_W'($urandom_range(cnt, 1))
				: ffra_pkg::FIELD_W'($urandom_range((cnt < 16) ? cnt : 16, 1));
		end
		return r;
	endfunction

	row_t script[$];
	int counts[] = '{0, 1, 2047, 5, 37, 700, 1024, 128};

	function automatic row_t mk(logic k, int f, int l, bit t, logic tf, int ts);
		row_t r;
		r.kind = k; r.first = ffra_pkg::FIELD_W'(f); r.len = ffra_pkg::FIELD_W'(l);
		r.typed = t; r.t_found = tf; r.t_start = ffra_pkg::FIELD_W'(ts);
		return r;
	endfunction

	initial begin
		script = '{
			mk(ffra_pkg::REQ_ALLOC,   0,    0,    1, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    1,    1, 1, 1),
			mk(ffra_pkg::REQ_ALLOC,   2047, 2047, 1, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    1024, 1, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    1023, 1, 1, 2),
			mk(ffra_pkg::REQ_ALLOC,   0,    1,    1, 0, 0),
			mk(ffra_pkg::REQ_RELEASE, 0,    1,    0, 0, 0),
			mk(ffra_pkg::REQ_RELEASE, 0,    2,    0, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    1,    1, 1, 1),
			mk(ffra_pkg::REQ_RELEASE, 2047, 2047, 0, 0, 0),
			mk(ffra_pkg::REQ_RELEASE, 1000, 2047, 0, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    25,   1, 1, 1000),
			mk(ffra_pkg::REQ_RELEASE, 1,    0,    0, 0, 0),
			mk(ffra_pkg::REQ_RELEASE, 1,    1024, 0, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    1024, 1, 1, 1),
			mk(ffra_pkg::REQ_RELEASE, 1,    1024, 0, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   1365, 3,    0, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   682,  1365, 0, 0, 0),
			mk(ffra_pkg::REQ_RELEASE, 2,    1,    0, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    1,    0, 0, 0),
			mk(ffra_pkg::REQ_RELEASE, 682,  682,  0, 0, 0),
			mk(ffra_pkg::REQ_ALLOC,   0,    700,  0, 0, 0)
		};
		rebuild_map(SLOTS);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		foreach (script[i])
			send(script[i]);
		settle();
		foreach (counts[p]) begin
			write_count(ffra_pkg::FIELD_W'(counts[p]));
			repeat (RAND_ITEMS / $size(counts)) begin
				// about six allocates in ten, the rest release runs
				send(pick(live_slots));
			end
			settle();
		end
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/ffra_pkg.sv
design/ffra_ram.sv
design/ffra_ctrl.sv
design/ffra_dp.sv
design/first_fit_run_allocator.sv
verif/testbench.sv
